### rtl/core/lkc_pkg.sv
`default_nettype none
package lkc_pkg;

	localparam int ENTRIES_DEF    = 16;
	localparam int KEY_BITS_DEF   = 64;
	localparam int VALUE_BITS_DEF = 64;
	localparam int TIME_BITS      = 48;

	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

	// item actions
	localparam logic [2:0] ACT_GET    = 3'd0;
	localparam logic [2:0] ACT_PUT    = 3'd1;
	localparam logic [2:0] ACT_REMOVE = 3'd2;
	localparam logic [2:0] ACT_CLEAR  = 3'd3;
	localparam logic [2:0] ACT_TICK   = 3'd4;

	// register indexes
	localparam logic [7:0] REG_CAPACITY    = 8'd0;
	localparam logic [7:0] REG_DEFAULT_TTL = 8'd1;

	// commands broadcast to the row of cells
	localparam logic [2:0] CMD_NONE   = 3'd0;
	localparam logic [2:0] CMD_MATCH  = 3'd1;
	localparam logic [2:0] CMD_TOUCH  = 3'd2;
	localparam logic [2:0] CMD_DROP   = 3'd3;
	localparam logic [2:0] CMD_INSERT = 3'd4;
	localparam logic [2:0] CMD_CLEAR  = 3'd5;

	typedef struct packed {
		logic [2:0] op;
		logic       wr;
		logic       has_life;
	} lkc_cmd_t;

endpackage
`default_nettype wire

### rtl/core/lkc_cell.sv
`default_nettype none
module lkc_cell import lkc_pkg::*; #(
	parameter int KEY_BITS   = KEY_BITS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int RW         = 4
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  lkc_cmd_t              cmd,
	input  wire  [KEY_BITS-1:0]   key,
	input  wire  [VALUE_BITS-1:0] value,
	input  wire  [TIME_BITS-1:0]  deadline,
	input  wire  [TIME_BITS-1:0]  now,
	input  wire  [RW-1:0]         rank_ref,
	input  wire  [RW-1:0]         cap_m1,
	input  wire                   hit_in,
	input  wire  [RW-1:0]         rank_in,
	input  wire  [VALUE_BITS-1:0] val_in,
	input  wire                   exp_in,
	input  wire                   free_in,
	output logic                  hit_out,
	output logic [RW-1:0]         rank_out,
	output logic [VALUE_BITS-1:0] val_out,
	output logic                  exp_out,
	output logic                  free_out
);

	logic                  valid_q, hit_q, exp_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic                  life_q;
	logic [TIME_BITS-1:0]  dl_q;
	logic [RW-1:0]         rank_q;

	logic evict, empty_after, sel;

	assign evict       = valid_q && (rank_q >= cap_m1);
	assign empty_after = (cmd.op == CMD_INSERT) ? !(valid_q && !evict) : !valid_q;
	assign sel         = free_in && empty_after;

	// pass the gathered hit and the free-slot token on to the next cell
	assign hit_out  = hit_in | hit_q;
	assign rank_out = rank_in | (hit_q ? rank_q : '0);
	assign val_out  = val_in | (hit_q ? val_q : '0);
	assign exp_out  = exp_in | (hit_q & exp_q);
	assign free_out = free_in && !empty_after;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hit_q   <= 1'b0;
			exp_q   <= 1'b0;
		end else begin
			case (cmd.op)
				CMD_MATCH: begin
					hit_q <= valid_q && (key_q == key);
					exp_q <= life_q && (now >= dl_q);
				end
				CMD_DROP: begin
					if (hit_q) valid_q <= 1'b0;
				end
				CMD_INSERT: begin
					if (evict) valid_q <= 1'b0;
					if (sel) valid_q <= 1'b1;
				end
				CMD_CLEAR: begin
					valid_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			CMD_TOUCH: begin
				if (hit_q) begin
					rank_q <= '0;
					if (cmd.wr) begin
						val_q  <= value;
						life_q <= cmd.has_life;
						dl_q   <= deadline;
					end
				end else if (valid_q && rank_q < rank_ref) begin
					rank_q <= rank_q + 1'b1;
				end
			end
			CMD_DROP: begin
				if (!hit_q && valid_q && rank_q > rank_ref) rank_q <= rank_q - 1'b1;
			end
			CMD_INSERT: begin
				if (sel) begin
					key_q  <= key;
					val_q  <= value;
					life_q <= cmd.has_life;
					dl_q   <= deadline;
					rank_q <= '0;
				end else if (valid_q && !evict) begin
					rank_q <= rank_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

### rtl/core/lru_key_value_cache_with_expiry.sv
// Each item runs a key match cycle in every cell, a gather cycle along the chain of cells,
// an update cycle broadcast to the row, then the idle cycle; the next item is taken only
// in the idle cycle and while no result waits in the skid register.
// A stalled result holds in the output register while the next item runs; a second
// result parks in a skid register and stalls the input. Reset (arst_n low, asynchronous):
// entries invalid, time, count, capacity and default ttl zero; no clearing pass is needed.
`default_nettype none
module lru_key_value_cache_with_expiry import lkc_pkg::*; #(
	parameter int ENTRIES    = ENTRIES_DEF,
	parameter int KEY_BITS   = KEY_BITS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [2:0]  action,
	input  wire  [63:0] key,
	input  wire  [63:0] value,
	input  wire  [31:0] ttl,
	output logic        out_valid,
	input  wire         out_stall,
	output logic        found,
	output logic [63:0] read_value,
	output logic [4:0]  entry_count,
	output logic [4:0]  evicted_count,
	output logic        expired_dropped,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [7:0]  cfg_index,
	input  wire  [31:0] cfg_data
);

	localparam int CW = $clog2(ENTRIES + 1);
	localparam int RW = $clog2(ENTRIES);

	// sequencer codes
	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_LOOK   = 2'd1;
	localparam logic [1:0] S_GATHER = 2'd2;
	localparam logic [1:0] S_APPLY  = 2'd3;

	logic [1:0] state_q;

	// configuration
	logic [4:0]  capacity_q;
	logic [31:0] dttl_q;

	// item held while it works through the cells
	logic [2:0]            act_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [31:0]           ttl_q;

	// gathered hit, registered at the end of the gather cycle
	logic                  hit_q, exp_q, life_q;
	logic [RW-1:0]         rank_q;
	logic [VALUE_BITS-1:0] hval_q;
	logic [TIME_BITS-1:0]  dl_q;

	logic [TIME_BITS-1:0] now_q;
	logic [CW-1:0]        held_q;

	// result waiting for the output register
	logic        pend_q;
	logic        p_found, p_exp;
	logic [63:0] p_val;
	logic [4:0]  p_cnt, p_evc;

	lkc_cmd_t cmd;

	logic                  hit_c [ENTRIES+1];
	logic [RW-1:0]         rank_c [ENTRIES+1];
	logic [VALUE_BITS-1:0] val_c [ENTRIES+1];
	logic                  exp_c [ENTRIES+1];
	logic                  free_c [ENTRIES+1];

	assign hit_c[0]  = 1'b0;
	assign rank_c[0] = '0;
	assign val_c[0]  = '0;
	assign exp_c[0]  = 1'b0;
	assign free_c[0] = 1'b1;

	// effective capacity: zero or above the table size means the whole table
	logic [CW-1:0] cap_eff;
	logic [RW-1:0] cap_m1;
	assign cap_eff = (capacity_q == 5'd0 || 32'(capacity_q) > ENTRIES)
		? CW'(ENTRIES) : CW'(capacity_q);
	assign cap_m1  = RW'(cap_eff - 1'b1);

	// resolved lifetime and saturated deadline
	logic [31:0]          t_res;
	logic [TIME_BITS:0]   dl_sum;
	assign t_res  = (ttl_q != 32'd0) ? ttl_q : dttl_q;
	assign dl_sum = {1'b0, now_q} + (TIME_BITS + 1)'(t_res);

	// the row of cells
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		lkc_cell #(
			.KEY_BITS  (KEY_BITS),
			.VALUE_BITS(VALUE_BITS),
			.RW        (RW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.key     (key_q),
			.value   (val_q),
			.deadline(dl_q),
			.now     (now_q),
			.rank_ref(rank_q),
			.cap_m1  (cap_m1),
			.hit_in  (hit_c[i]),
			.rank_in (rank_c[i]),
			.val_in  (val_c[i]),
			.exp_in  (exp_c[i]),
			.free_in (free_c[i]),
			.hit_out (hit_c[i+1]),
			.rank_out(rank_c[i+1]),
			.val_out (val_c[i+1]),
			.exp_out (exp_c[i+1]),
			.free_out(free_c[i+1])
		);
	end

	// Pick the update for the apply cycle from the action and the gathered hit.
	logic          r_found, r_exp;
	logic [63:0]   r_val;
	logic [CW-1:0] r_held, r_evc;

	always_comb begin
		cmd          = '0;
		cmd.has_life = life_q;
		r_found      = 1'b0;
		r_exp        = 1'b0;
		r_val        = '0;
		r_held       = held_q;
		r_evc        = '0;
		case (state_q)
			S_LOOK: cmd.op = CMD_MATCH;
			S_APPLY: begin
				case (act_q)
					ACT_GET: begin
						if (hit_q && exp_q) begin
							cmd.op = CMD_DROP;
							r_exp  = 1'b1;
							if (held_q != '0) r_held = held_q - 1'b1;
						end else if (hit_q) begin
							cmd.op  = CMD_TOUCH;
							r_found = 1'b1;
							r_val   = 64'(hval_q);
						end
					end
					ACT_PUT: begin
						cmd.wr = 1'b1;
						if (hit_q) begin
							cmd.op = CMD_TOUCH;
						end else begin
							// evict every rank at or past cap-1, then insert
							cmd.op = CMD_INSERT;
							if (held_q >= cap_eff) begin
								r_evc  = held_q - cap_eff + 1'b1;
								r_held = cap_eff;
							end else begin
								r_held = held_q + 1'b1;
							end
						end
					end
					ACT_REMOVE: begin
						if (hit_q) begin
							cmd.op  = CMD_DROP;
							r_found = 1'b1;
							if (held_q != '0) r_held = held_q - 1'b1;
						end
					end
					ACT_CLEAR: begin
						cmd.op = CMD_CLEAR;
						r_held = '0;
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	logic out_free;
	assign out_free  = !out_valid || !out_stall;
	assign in_stall  = (state_q != S_IDLE) || pend_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			capacity_q <= '0;
			dttl_q     <= '0;
			now_q      <= '0;
			held_q     <= '0;
			pend_q     <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_CAPACITY:    capacity_q <= cfg_data[4:0];
					REG_DEFAULT_TTL: dttl_q     <= cfg_data;
					default: begin
					end
				endcase
			end
			// a fresh result goes out or parks; otherwise drain the skid result
			if (state_q == S_APPLY) begin
				if (out_free) out_valid <= 1'b1;
				else pend_q <= 1'b1;
			end else if (out_free) begin
				out_valid <= pend_q;
				pend_q    <= 1'b0;
			end
			case (state_q)
				S_IDLE:   if (in_valid && !in_stall) state_q <= S_LOOK;
				S_LOOK:   state_q <= S_GATHER;
				S_GATHER: state_q <= S_APPLY;
				S_APPLY: begin
					state_q <= S_IDLE;
					held_q  <= r_held;
					if (act_q == ACT_TICK && now_q != TIME_MAX) now_q <= now_q + 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid && !in_stall) begin
			act_q <= action;
			key_q <= key[KEY_BITS-1:0];
			val_q <= value[VALUE_BITS-1:0];
			ttl_q <= ttl;
		end
		if (state_q == S_GATHER) begin
			hit_q  <= hit_c[ENTRIES];
			rank_q <= rank_c[ENTRIES];
			hval_q <= val_c[ENTRIES];
			exp_q  <= exp_c[ENTRIES];
			life_q <= t_res != 32'd0;
			dl_q   <= dl_sum[TIME_BITS] ? TIME_MAX : dl_sum[TIME_BITS-1:0];
		end
		if (state_q == S_APPLY) begin
			p_found <= r_found;
			p_exp   <= r_exp;
			p_val   <= r_val;
			p_cnt   <= 5'(r_held);
			p_evc   <= 5'(r_evc);
		end
		// load the output register from the fresh result, else from the skid
		if (out_free && state_q == S_APPLY && !pend_q) begin
			found           <= r_found;
			expired_dropped <= r_exp;
			read_value      <= r_val;
			entry_count     <= 5'(r_held);
			evicted_count   <= 5'(r_evc);
		end else if (out_free && pend_q) begin
			found           <= p_found;
			expired_dropped <= p_exp;
			read_value      <= p_val;
			entry_count     <= p_cnt;
			evicted_count   <= p_evc;
		end
	end

endmodule
`default_nettype wire

### rtl/core/lkc_checker.sv
`default_nettype none
module lkc_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_stall,
	input wire        out_valid,
	input wire        out_stall,
	input wire        found,
	input wire [63:0] read_value,
	input wire [4:0]  evicted_count,
	input wire        expired_dropped
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_value) && $stable(found))
		else $error("stalled result changed");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(found && expired_dropped))
		else $error("hit and expiry drop together");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> read_value == 64'd0)
		else $error("miss carries a value");

	a_evict_put: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && evicted_count != 5'd0 |-> !found && !expired_dropped)
		else $error("eviction on a non-insert");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("item taken while busy");

endmodule

bind lru_key_value_cache_with_expiry lkc_checker u_lkc_checker (.*);
`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import lkc_pkg::*;

	localparam int SLOTS = 16;

	typedef struct packed {
		logic [2:0]  action;
		logic [63:0] key;
		logic [63:0] value;
		logic [31:0] ttl;
	} cache_req_t;

	typedef struct packed {
		logic        found;
		logic [63:0] read_value;
		logic [4:0]  entry_count;
		logic [4:0]  evicted_count;
		logic        expired_dropped;
	} cache_rsp_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  action;
	logic [63:0] key;
	logic [63:0] value;
	logic [31:0] ttl;
	logic        out_valid;
	logic        out_stall;
	logic        found;
	logic [63:0] read_value;
	logic [4:0]  entry_count;
	logic [4:0]  evicted_count;
	logic        expired_dropped;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_index;
	logic [31:0] cfg_data;

	lru_key_value_cache_with_expiry u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .key(key), .value(value), .ttl(ttl),
		.out_valid(out_valid), .out_stall(out_stall),
		.found(found), .read_value(read_value), .entry_count(entry_count),
		.evicted_count(evicted_count), .expired_dropped(expired_dropped),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Shadow copy of the cache contents, updated as items are accepted.
	logic        sh_valid [SLOTS];
	logic [63:0] sh_key [SLOTS];
	logic [63:0] sh_value [SLOTS];
	logic        sh_life [SLOTS];
	logic [47:0] sh_deadline [SLOTS];
	int          sh_rank [SLOTS];
	logic [47:0] sh_now;
	int          sh_held;
	logic [4:0]  sh_capacity;
	logic [31:0] sh_default_ttl;

	cache_req_t  pending_reqs[$];
	cache_rsp_t  expected_rsps[$];
	int          error_count;
	int          accepted_count;
	bit          quiet_tail;
	bit          hold_off_req;
	int          hold_off_cycles;
	bit          in_took;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic int find_entry(logic [63:0] k);
		for (int i = 0; i < SLOTS; i++)
			if (sh_valid[i] && sh_key[i] == k)
				return i;
		return -1;
	endfunction

	function automatic void drop_entry(int s);
		int r;
		r = sh_rank[s];
		sh_valid[s] = 1'b0;
		for (int i = 0; i < SLOTS; i++)
			if (sh_valid[i] && sh_rank[i] > r)
				sh_rank[i]--;
		if (sh_held > 0)
			sh_held--;
	endfunction

	function automatic void touch_entry(int s);
		int r;
		r = sh_rank[s];
		for (int i = 0; i < SLOTS; i++)
			if (i != s && sh_valid[i] && sh_rank[i] < r)
				sh_rank[i]++;
		sh_rank[s] = 0;
	endfunction

	function automatic void set_deadline(int s, logic [31:0] t_in);
		logic [48:0] d;
		logic [31:0] t;
		t = (t_in != 0) ? t_in : sh_default_ttl;
		d = {1'b0, sh_now} + 49'(t);
		sh_life[s] = (t != 0);
		sh_deadline[s] = d[48] ? TIME_MAX : d[47:0];
	endfunction

	// Work out the result of one accepted item and advance the shadow state.
	function automatic cache_rsp_t predict_access(cache_req_t rq);
		cache_rsp_t rs;
		int s, cap, victim;
		rs = '0;
		case (rq.action)
			ACT_GET: begin
				s = find_entry(rq.key);
				if (s >= 0) begin
					if (sh_life[s] && sh_now >= sh_deadline[s]) begin
						drop_entry(s);
						rs.expired_dropped = 1'b1;
					end else begin
						touch_entry(s);
						rs.found = 1'b1;
						rs.read_value = sh_value[s];
					end
				end
			end
			ACT_PUT: begin
				s = find_entry(rq.key);
				if (s >= 0) begin
					sh_value[s] = rq.value;
					set_deadline(s, rq.ttl);
					touch_entry(s);
				end else begin
					cap = sh_capacity;
					if (cap == 0 || cap > SLOTS)
						cap = SLOTS;
					while (sh_held >= cap) begin
						victim = -1;
						for (int i = 0; i < SLOTS; i++)
							if (sh_valid[i] && (victim < 0 || sh_rank[i] > sh_rank[victim]))
								victim = i;
						if (victim < 0) begin
							sh_held = 0;
							break;
						end
						drop_entry(victim);
						rs.evicted_count++;
					end
					s = -1;
					for (int i = 0; i < SLOTS; i++)
						if (!sh_valid[i] && s < 0)
							s = i;
					if (s >= 0) begin
						for (int i = 0; i < SLOTS; i++)
							if (sh_valid[i])
								sh_rank[i]++;
						sh_valid[s] = 1'b1;
						sh_key[s] = rq.key;
						sh_value[s] = rq.value;
						set_deadline(s, rq.ttl);
						sh_rank[s] = 0;
						sh_held++;
					end
				end
			end
			ACT_REMOVE: begin
				s = find_entry(rq.key);
				if (s >= 0) begin
					drop_entry(s);
					rs.found = 1'b1;
				end
			end
			ACT_CLEAR: begin
				for (int i = 0; i < SLOTS; i++)
					sh_valid[i] = 1'b0;
				sh_held = 0;
			end
			ACT_TICK: begin
				if (sh_now != TIME_MAX)
					sh_now++;
			end
			default: ;
		endcase
		rs.entry_count = 5'(sh_held);
		return rs;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h want %0h", what, got, want);
		error_count++;
	endtask

	// Take note of an accepted item at the rising edge and predict its result.
	always @(posedge clk) begin
		in_took = arst_n && in_valid && !in_stall;
		if (in_took) begin
			expected_rsps.insert(expected_rsps.size(),
				predict_access(pending_reqs.pop_front()));
			accepted_count++;
		end
	end

	// Sender: present the head of the queue, hold it until taken, idle in bursts.
	int send_gap;
	always @(negedge clk) begin
		if (arst_n && !(in_valid && !in_took)) begin
			if (send_gap > 0 && !quiet_tail) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pending_reqs.size() > 0 &&
					(quiet_tail || $urandom_range(0, 9) != 0)) begin
				in_valid <= 1'b1;
				{action, key, value, ttl} <= pending_reqs[0];
			end else begin
				in_valid <= 1'b0;
				if (!quiet_tail && pending_reqs.size() > 0)
					send_gap = $urandom_range(0, 11);
			end
		end
	end

	// Receiver: stall in random bursts, plus one long hold-off on request.
	int recv_gap;
	always @(negedge clk) begin
		if (hold_off_req) begin
			out_stall <= 1'b1;
			if (hold_off_cycles > 0)
				hold_off_cycles--;
			else
				hold_off_req = 1'b0;
		end else if (recv_gap > 0 && !quiet_tail) begin
			recv_gap--;
			out_stall <= 1'b1;
		end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
			recv_gap = $urandom_range(0, 11);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Check each accepted result against the oldest expectation.
	always @(posedge clk) begin
		cache_rsp_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_rsps.size() == 0) begin
				report_mismatch("unexpected item", 0, 0);
			end else begin
				want = expected_rsps.pop_front();
				if (found !== want.found)
					report_mismatch("found", found, want.found);
				if (read_value !== want.read_value)
					report_mismatch("read_value", read_value, want.read_value);
				if (entry_count !== want.entry_count)
					report_mismatch("entry_count", entry_count, want.entry_count);
				if (evicted_count !== want.evicted_count)
					report_mismatch("evicted_count", evicted_count, want.evicted_count);
				if (expired_dropped !== want.expired_dropped)
					report_mismatch("expired_dropped", expired_dropped,
						want.expired_dropped);
			end
		end
	end

	task automatic write_reg(logic [7:0] idx, logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == REG_CAPACITY)
			sh_capacity = data[4:0];
		else
			sh_default_ttl = data;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain_all();
		while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic void queue_item(logic [2:0] a, logic [63:0] k, logic [63:0] v,
			logic [31:0] t);
		cache_req_t rq;
		rq = '{a, k, v, t};
		pending_reqs.insert(pending_reqs.size(), rq);
	endfunction

	// Random key from a small pool so hits, updates and evictions are common;
	// now and then a fully random key for bit coverage.
	function automatic logic [63:0] pick_key(int pool);
		if ($urandom_range(0, 15) == 0)
			return {$urandom, $urandom};
		return 64'hA5A5_0000_0000_0000 | 64'($urandom_range(0, pool - 1));
	endfunction

	function automatic logic [31:0] pick_ttl();
		case ($urandom_range(0, 5))
			0, 1: return 32'd0;
			2: return $urandom;
			3: return 32'hFFFF_FFFF;
			default: return 32'($urandom_range(1, 6));
		endcase
	endfunction

	task automatic queue_random(int n, int pool);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 35)
				queue_item(ACT_GET, pick_key(pool), {$urandom, $urandom}, $urandom);
			else if (r < 70)
				queue_item(ACT_PUT, pick_key(pool), {$urandom, $urandom}, pick_ttl());
			else if (r < 80)
				queue_item(ACT_REMOVE, pick_key(pool), {$urandom, $urandom}, $urandom);
			else if (r < 81)
				queue_item(ACT_CLEAR, {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
			else if (r < 98)
				queue_item(ACT_TICK, {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
			else
				queue_item(3'($urandom_range(5, 7)), pick_key(pool),
					{$urandom, $urandom}, $urandom);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = '0;
		key = '0;
		value = '0;
		ttl = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		error_count = 0;
		accepted_count = 0;
		quiet_tail = 1'b0;
		hold_off_req = 1'b0;
		hold_off_cycles = 0;
		in_took = 1'b0;
		send_gap = 0;
		recv_gap = 0;
		for (int i = 0; i < SLOTS; i++) begin
			sh_valid[i] = 1'b0;
			sh_key[i] = '0;
			sh_value[i] = '0;
			sh_life[i] = 1'b0;
			sh_deadline[i] = '0;
			sh_rank[i] = 0;
		end
		sh_now = '0;
		sh_held = 0;
		sh_capacity = '0;
		sh_default_ttl = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: extremes of key and value, expiry, update, remove of expired,
		// eviction at full table, unknown actions, clear.
		queue_item(ACT_GET, 64'h0, 64'h0, 32'h0);
		queue_item(ACT_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
		queue_item(ACT_PUT, 64'h0, 64'h0, 32'd2);
		queue_item(ACT_GET, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 32'h0);
		queue_item(ACT_TICK, 64'h0, 64'h0, 32'h0);
		queue_item(ACT_GET, 64'h0, 64'h0, 32'h0);
		queue_item(ACT_TICK, 64'h0, 64'h0, 32'h0);
		queue_item(ACT_GET, 64'h0, 64'h0, 32'h0);
		queue_item(ACT_PUT, 64'h1, 64'h1234, 32'd1);
		queue_item(ACT_PUT, 64'h1, 64'h5678, 32'hFFFF_FFFF);
		queue_item(ACT_PUT, 64'h2, 64'h9, 32'd1);
		queue_item(ACT_TICK, 64'h0, 64'h0, 32'h0);
		queue_item(ACT_REMOVE, 64'h2, 64'h0, 32'h0);
		queue_item(ACT_REMOVE, 64'h2, 64'h0, 32'h0);
		for (int i = 0; i < 17; i++)
			queue_item(ACT_PUT, 64'h100 + 64'(i), 64'(i), 32'd0);
		queue_item(ACT_GET, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 32'h0);
		queue_item(3'd5, 64'h1, 64'h1, 32'h1);
		queue_item(3'd7, 64'h1, 64'h1, 32'h1);
		queue_item(ACT_CLEAR, 64'h0, 64'h0, 32'h0);
		drain_all();

		// Small capacity with a default lifetime; long receiver hold-off.
		write_reg(REG_CAPACITY, 32'd1);
		write_reg(REG_DEFAULT_TTL, 32'd3);
		hold_off_cycles = 300;
		hold_off_req = 1'b1;
		queue_random(200, 6);
		drain_all();

		write_reg(REG_CAPACITY, 32'd16);
		write_reg(REG_DEFAULT_TTL, 32'hFFFF_FFFF);
		queue_random(250, 24);
		drain_all();

		write_reg(REG_CAPACITY, 32'd31);
		write_reg(REG_DEFAULT_TTL, 32'd0);
		queue_random(250, 24);
		drain_all();

		write_reg(REG_CAPACITY, 32'd4);
		write_reg(REG_DEFAULT_TTL, 32'd5);
		queue_random(250, 10);
		drain_all();

		// Tail: no idling on either side.
		write_reg(REG_CAPACITY, 32'd0);
		write_reg(REG_DEFAULT_TTL, 32'd2);
		quiet_tail = 1'b1;
		queue_random(250, 20);
		drain_all();

		if (error_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

	initial begin
		#5ms;
		$display("tb_top: done, errors");
		$finish;
	end

endmodule
